FILE: rtl/ntrl_pkg.sv
package ntrl_pkg;

    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = 32;
    localparam int OUT_W   = 48;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [NIB_W-1:0] SIZE_MIN = 4'd1;
    localparam logic [NIB_W-1:0] SIZE_MAX = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START_VCN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_VCN   = 1'd1;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_LEN  = 2'd1;
    localparam t_status ST_BAD_OFF  = 2'd2;
    localparam t_status ST_NEG_LCN  = 2'd3;

    localparam logic [CNT_W-1:0] BYTES_1 = 3'd1;
    localparam logic [CNT_W-1:0] BYTES_2 = 3'd2;
    localparam logic [CNT_W-1:0] BYTES_3 = 3'd3;
    localparam logic [CNT_W-1:0] BYTES_4 = 3'd4;

endpackage

FILE: rtl/ntrl_lcn_calc.sv
module ntrl_lcn_calc
    import ntrl_pkg::*;
#(
    parameter int CLUSTER_WIDTH = 48
) (
    input  logic [ACC_W-1:0]         i_offset,
    input  logic [CNT_W-1:0]         i_offset_bytes,
    input  logic [CLUSTER_WIDTH-1:0] i_prev_lcn,
    output logic [CLUSTER_WIDTH-1:0] o_lcn,
    output logic                     o_negative
);

    logic                     sign;
    logic [ACC_W:0]           mag;
    logic [CLUSTER_WIDTH:0]   diff;
    logic [CLUSTER_WIDTH-1:0] sum;

    always_comb begin
        case (i_offset_bytes)
            BYTES_1: begin
                sign = i_offset[7];
                mag  = 33'h1_0000_0100 - {1'b1, i_offset};
            end
            BYTES_2: begin
                sign = i_offset[15];
                mag  = 33'h1_0001_0000 - {1'b1, i_offset};
            end
            BYTES_3: begin
                sign = i_offset[23];
                mag  = 33'h1_0100_0000 - {1'b1, i_offset};
            end
            BYTES_4: begin
                sign = i_offset[31];
                mag  = 33'h1_0000_0000 - {1'b0, i_offset};
            end
            default: begin
                sign = 1'b0;
                mag  = '0;
            end
        endcase
    end

    assign diff = {1'b0, i_prev_lcn} - (CLUSTER_WIDTH+1)'(mag);
    assign sum  = i_prev_lcn + CLUSTER_WIDTH'(i_offset);

    assign o_negative = sign & diff[CLUSTER_WIDTH];
    assign o_lcn      = sign ? diff[CLUSTER_WIDTH-1:0] : sum;

endmodule

FILE: rtl/ntfs_runlist_decoder.sv
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   i_run_byte, i_list_begin
// output    o_out_valid / i_out_ready o_run_vcn, o_run_lcn, o_run_length, o_status,
//                                     o_list_done
// config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One byte per cycle while o_in_ready is high; a result registers on its last byte.
// The parser state and the result register update in the same cycle the byte is taken.
// Reset leaves the parser idle until a byte with i_list_begin arrives.
// A result waiting on i_out_ready stalls the input only while it is not being taken.
module ntfs_runlist_decoder
    import ntrl_pkg::*;
#(
    parameter int CLUSTER_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_run_byte,
    input  logic                 i_list_begin,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_run_vcn,
    output logic [OUT_W-1:0]     o_run_lcn,
    output logic [ACC_W-1:0]     o_run_length,
    output logic [1:0]           o_status,
    output logic                 o_list_done
);

    localparam int CW = CLUSTER_WIDTH;
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET
    } t_phase;

    logic [CFG_W-1:0] r_start_vcn, n_start_vcn;
    logic [CFG_W-1:0] r_end_vcn, n_end_vcn;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_bytes_left, n_bytes_left;
    logic [CNT_W-1:0] r_len_bytes, n_len_bytes;
    logic [CNT_W-1:0] r_off_bytes, n_off_bytes;
    logic [ACC_W-1:0] r_len_acc, n_len_acc;
    logic [ACC_W-1:0] r_off_acc, n_off_acc;
    logic [CW-1:0]    r_vcn, n_vcn;
    logic [CW-1:0]    r_prev_lcn, n_prev_lcn;
    logic             r_finished, n_finished;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_run_vcn, n_run_vcn;
    logic [OUT_W-1:0] r_run_lcn, n_run_lcn;
    logic [ACC_W-1:0] r_run_length, n_run_length;
    t_status          r_status, n_status;
    logic             r_list_done, n_list_done;

    logic             in_fire;
    t_phase           cur_phase;
    logic [CNT_W-1:0] cur_bytes_left;
    logic [ACC_W-1:0] cur_len_acc;
    logic [ACC_W-1:0] cur_off_acc;
    logic [CW-1:0]    cur_vcn;
    logic [CW-1:0]    cur_prev_lcn;
    logic             cur_finished;
    logic [CNT_W-1:0] left_dec;
    logic [1:0]       len_idx;
    logic [1:0]       off_idx;
    logic [ACC_W-1:0] len_new;
    logic [ACC_W-1:0] off_new;
    logic [NIB_W-1:0] len_nib;
    logic [NIB_W-1:0] off_nib;
    logic [CW-1:0]    calc_lcn;
    logic             calc_neg;
    logic [CW:0]      vcn_sum;
    logic             vcn_past;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign cur_phase      = i_list_begin ? PH_HEADER : r_phase;
    assign cur_bytes_left = i_list_begin ? '0 : r_bytes_left;
    assign cur_len_acc    = i_list_begin ? '0 : r_len_acc;
    assign cur_off_acc    = i_list_begin ? '0 : r_off_acc;
    assign cur_vcn        = i_list_begin ? CW'(r_start_vcn) : r_vcn;
    assign cur_prev_lcn   = i_list_begin ? '0 : r_prev_lcn;
    assign cur_finished   = i_list_begin ? (r_start_vcn > r_end_vcn) : r_finished;

    assign left_dec = cur_bytes_left - CNT_W'(1);
    assign len_idx  = 2'(r_len_bytes - cur_bytes_left);
    assign off_idx  = 2'(r_off_bytes - cur_bytes_left);
    assign len_new  = cur_len_acc | (ACC_W'(i_run_byte) << {len_idx, 3'b000});
    assign off_new  = cur_off_acc | (ACC_W'(i_run_byte) << {off_idx, 3'b000});
    assign len_nib  = i_run_byte[NIB_W-1:0];
    assign off_nib  = i_run_byte[BYTE_W-1:NIB_W];

    ntrl_lcn_calc #(
        .CLUSTER_WIDTH(CW)
    ) u_lcn_calc (
        .i_offset      (off_new),
        .i_offset_bytes(r_off_bytes),
        .i_prev_lcn    (cur_prev_lcn),
        .o_lcn         (calc_lcn),
        .o_negative    (calc_neg)
    );

    assign vcn_sum  = {1'b0, cur_vcn} + (CW+1)'(cur_len_acc);
    assign vcn_past = vcn_sum[CW] || (EW'(vcn_sum[CW-1:0]) > EW'(r_end_vcn));

    always_comb begin
        n_start_vcn  = r_start_vcn;
        n_end_vcn    = r_end_vcn;
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_len_bytes  = r_len_bytes;
        n_off_bytes  = r_off_bytes;
        n_len_acc    = r_len_acc;
        n_off_acc    = r_off_acc;
        n_vcn        = r_vcn;
        n_prev_lcn   = r_prev_lcn;
        n_finished   = r_finished;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_run_vcn    = r_run_vcn;
        n_run_lcn    = r_run_lcn;
        n_run_length = r_run_length;
        n_status     = r_status;
        n_list_done  = r_list_done;

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_START_VCN) begin
                n_start_vcn = i_cfg_data;
            end else if (i_cfg_idx == REG_END_VCN) begin
                n_end_vcn = i_cfg_data;
            end
        end

        if (in_fire) begin
            n_phase      = cur_phase;
            n_bytes_left = cur_bytes_left;
            n_len_acc    = cur_len_acc;
            n_off_acc    = cur_off_acc;
            n_vcn        = cur_vcn;
            n_prev_lcn   = cur_prev_lcn;
            n_finished   = cur_finished;
            if (!cur_finished) begin
                case (cur_phase)
                    PH_LENGTH: begin
                        n_len_acc    = len_new;
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase      = PH_OFFSET;
                            n_bytes_left = r_off_bytes;
                        end
                    end
                    PH_OFFSET: begin
                        n_off_acc    = off_new;
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase     = PH_HEADER;
                            n_out_valid = 1'b1;
                            n_run_vcn   = OUT_W'(cur_vcn);
                            n_run_length = cur_len_acc;
                            if (calc_neg) begin
                                n_finished  = 1'b1;
                                n_run_lcn   = '0;
                                n_status    = ST_NEG_LCN;
                                n_list_done = 1'b1;
                            end else begin
                                n_run_lcn   = OUT_W'(calc_lcn);
                                n_status    = ST_OK;
                                n_list_done = vcn_past;
                                n_vcn       = vcn_sum[CW-1:0];
                                n_prev_lcn  = calc_lcn;
                                n_finished  = vcn_past;
                            end
                        end
                    end
                    default: begin
                        if (len_nib < SIZE_MIN || len_nib > SIZE_MAX) begin
                            n_finished   = 1'b1;
                            n_phase      = PH_HEADER;
                            n_out_valid  = 1'b1;
                            n_run_vcn    = OUT_W'(cur_vcn);
                            n_run_lcn    = '0;
                            n_run_length = '0;
                            n_status     = ST_BAD_LEN;
                            n_list_done  = 1'b1;
                        end else if (off_nib < SIZE_MIN || off_nib > SIZE_MAX) begin
                            n_finished   = 1'b1;
                            n_phase      = PH_HEADER;
                            n_out_valid  = 1'b1;
                            n_run_vcn    = OUT_W'(cur_vcn);
                            n_run_lcn    = '0;
                            n_run_length = '0;
                            n_status     = ST_BAD_OFF;
                            n_list_done  = 1'b1;
                        end else begin
                            n_len_bytes  = len_nib[CNT_W-1:0];
                            n_off_bytes  = off_nib[CNT_W-1:0];
                            n_len_acc    = '0;
                            n_off_acc    = '0;
                            n_bytes_left = len_nib[CNT_W-1:0];
                            n_phase      = PH_LENGTH;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vcn  <= '0;
            r_end_vcn    <= '0;
            r_phase      <= PH_HEADER;
            r_bytes_left <= '0;
            r_len_bytes  <= '0;
            r_off_bytes  <= '0;
            r_len_acc    <= '0;
            r_off_acc    <= '0;
            r_vcn        <= '0;
            r_prev_lcn   <= '0;
            r_finished   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_start_vcn  <= n_start_vcn;
            r_end_vcn    <= n_end_vcn;
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_len_bytes  <= n_len_bytes;
            r_off_bytes  <= n_off_bytes;
            r_len_acc    <= n_len_acc;
            r_off_acc    <= n_off_acc;
            r_vcn        <= n_vcn;
            r_prev_lcn   <= n_prev_lcn;
            r_finished   <= n_finished;
            r_out_valid  <= n_out_valid;
        end
        r_run_vcn    <= n_run_vcn;
        r_run_lcn    <= n_run_lcn;
        r_run_length <= n_run_length;
        r_status     <= n_status;
        r_list_done  <= n_list_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_vcn    = r_run_vcn;
    assign o_run_lcn    = r_run_lcn;
    assign o_run_length = r_run_length;
    assign o_status     = r_status;
    assign o_list_done  = r_list_done;

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_list_done)
        else $error("error item without list_done");

    a_err_lcn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_run_lcn == '0))
        else $error("error item with nonzero lcn");

    a_len_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_list_begin && r_phase == PH_LENGTH && !r_finished
         && (!r_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("item produced during length bytes");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_list_begin && r_finished && (!r_out_valid || i_out_ready))
        |=> !o_out_valid)
        else $error("item produced while idle");

endmodule
